// File: sv/usc_pkg.sv
`default_nettype none

package usc_pkg;

    // pipeline depth from an accepted start to the done beat
    localparam int LATENCY = 10;

    // configuration port
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_ZONE = 1'b0;
    localparam logic [4:0] ZONE_RESET = 5'd8;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;

    // reciprocals, each exact over the input width it is used at
    localparam logic [25:0] RECIP_675   = 26'd50903317;  // 25-bit input, shift 35
    localparam logic [17:0] RECIP_3600  = 18'd149131;    // 17-bit input, shift 29
    localparam logic [17:0] RECIP_60    = 18'd139811;    // 17-bit input, shift 23
    localparam logic [18:0] RECIP_1460  = 19'd367720;    // 18-bit input, shift 29
    localparam logic [18:0] RECIP_36524 = 19'd470373;    // 18-bit input, shift 34
    localparam logic [18:0] RECIP_365   = 19'd367720;    // 18-bit input, shift 27
    localparam logic [9:0]  RECIP_100   = 10'd656;       // 9-bit input, shift 16
    localparam logic [11:0] RECIP_153   = 12'd3427;      // 11-bit input, shift 19

    // day count split: days since 1970 where the 400-year era changes
    localparam logic [15:0] ERA5_FIRST_DAY = 16'd11017;
    localparam logic [17:0] ERA4_DOE_BASE  = 18'd135080;
    localparam logic [11:0] ERA4_YEAR      = 12'd1600;
    localparam logic [11:0] ERA5_YEAR      = 12'd2000;
    localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;

    // sign-extended hour offset scaled to seconds, modulo 2^32
    function automatic logic [31:0] zone_seconds(input logic [4:0] hours);
        logic [31:0] h32;
        h32 = {{27{hours[4]}}, hours};
        return h32 * SECS_PER_HOUR;
    endfunction

    // first day of each march-based month within the year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: sv/unix_seconds_to_calendar.sv
// throughput: one timestamp per cycle, busy stays low; the conversion runs in a
// ten-stage chain of adders and constant-reciprocal multipliers, one stage per register
// reset: asynchronous, active low; clears the valid chain and sets the zone
// offset back to +8 hours; the receiver cannot stall, done lasts one cycle
`default_nettype none

module unix_seconds_to_calendar (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [31:0]                utc_seconds,
    output logic                       done,
    output logic [11:0]                year,
    output logic [3:0]                 month,
    output logic [4:0]                 day_of_month,
    output logic [4:0]                 hour,
    output logic [5:0]                 minute,
    output logic [5:0]                 second,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [usc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import usc_pkg::*;

    typedef struct packed {
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
    } tod_t;

    // configuration register and its value in seconds
    logic [4:0]  zone_reg, zone_next;
    logic [31:0] zone_secs_reg, zone_secs_next;
    logic        wr_en;
    logic        in_acc;
    logic [LATENCY-1:0] vld_reg, vld_next;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign in_acc = start & ~busy;
    assign wr_en  = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_ZONE);

    always_comb
    begin
        zone_next      = zone_reg;
        zone_secs_next = zone_secs_reg;
        if (wr_en)
        begin
            zone_next      = pwdata[4:0];
            zone_secs_next = zone_seconds(pwdata[4:0]);
        end
    end

    // register read-back
    always_comb
    begin
        if (paddr[ADDR_W-1:2] == REG_ZONE)
            prdata = {27'd0, zone_reg};
        else
            prdata = '0;
    end

    // valid bits travel alongside the data
    assign vld_next = {vld_reg[LATENCY-2:0], in_acc};
    assign done     = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg      <= ZONE_RESET;
            zone_secs_reg <= zone_seconds(ZONE_RESET);
            vld_reg       <= '0;
        end
        else
        begin
            zone_reg      <= zone_next;
            zone_secs_reg <= zone_secs_next;
            vld_reg       <= vld_next;
        end
    end

    // stage 1: apply zone offset
    logic [31:0] s1_t_reg, s1_t_next;
    assign s1_t_next = utc_seconds + zone_secs_reg;

    // stage 2: day count by reciprocal of 675 on seconds over 128
    logic [50:0] s2_prod;
    logic [15:0] s2_days_reg, s2_days_next;
    logic [31:0] s2_t_reg;
    assign s2_prod      = s1_t_reg[31:7] * RECIP_675;
    assign s2_days_next = s2_prod[50:35];

    // stage 3: seconds of day and day of era
    logic [25:0] s3_prod;
    logic [24:0] s3_diff;
    logic [16:0] s3_rem_reg, s3_rem_next;
    logic [17:0] s3_doe_reg, s3_doe_next;
    logic        s3_era5_reg, s3_era5_next;
    assign s3_prod     = s2_days_reg * 10'd675;
    assign s3_diff     = s2_t_reg[31:7] - s3_prod[24:0];
    assign s3_rem_next = {s3_diff[9:0], s2_t_reg[6:0]};

    always_comb
    begin
        s3_era5_next = (s2_days_reg >= ERA5_FIRST_DAY);
        if (s3_era5_next)
            s3_doe_next = {2'b00, s2_days_reg} - {2'b00, ERA5_FIRST_DAY};
        else
            s3_doe_next = {2'b00, s2_days_reg} + ERA4_DOE_BASE;
    end

    // stage 4: hours, total minutes and leap corrections
    logic [34:0] s4_prod_h, s4_prod_m;
    logic [36:0] s4_prod_a, s4_prod_b;
    logic [4:0]  s4_hr_reg, s4_hr_next;
    logic [10:0] s4_mins_reg, s4_mins_next;
    logic [6:0]  s4_a_reg, s4_a_next;
    logic [2:0]  s4_b_reg, s4_b_next;
    logic        s4_c_reg, s4_c_next;
    logic [16:0] s4_rem_reg;
    logic [17:0] s4_doe_reg;
    logic        s4_era5_reg;
    assign s4_prod_h    = s3_rem_reg * RECIP_3600;
    assign s4_prod_m    = s3_rem_reg * RECIP_60;
    assign s4_prod_a    = s3_doe_reg * RECIP_1460;
    assign s4_prod_b    = s3_doe_reg * RECIP_36524;
    assign s4_hr_next   = s4_prod_h[33:29];
    assign s4_mins_next = s4_prod_m[33:23];
    assign s4_a_next    = s4_prod_a[35:29];
    assign s4_b_next    = s4_prod_b[36:34];
    assign s4_c_next    = (s3_doe_reg == LAST_ERA_DAY);

    // stage 5: minute and second, leap-adjusted day of era
    logic [16:0] s5_m60;
    logic [10:0] s5_h60;
    logic [16:0] s5_sdiff;
    logic [10:0] s5_mdiff;
    tod_t        s5_tod_reg, s5_tod_next;
    logic [17:0] s5_n_reg, s5_n_next;
    logic [17:0] s5_doe_reg;
    logic        s5_era5_reg;
    assign s5_m60    = s4_mins_reg * 6'd60;
    assign s5_h60    = s4_hr_reg * 6'd60;
    assign s5_sdiff  = s4_rem_reg - s5_m60;
    assign s5_mdiff  = s4_mins_reg - s5_h60;
    assign s5_tod_next = '{hr: s4_hr_reg, mn: s5_mdiff[5:0], sc: s5_sdiff[5:0]};
    assign s5_n_next = s4_doe_reg - {11'd0, s4_a_reg} + {15'd0, s4_b_reg}
                       - {17'd0, s4_c_reg};

    // stage 6: year of era
    logic [36:0] s6_prod;
    logic [8:0]  s6_yoe_reg, s6_yoe_next;
    tod_t        s6_tod_reg;
    logic [17:0] s6_doe_reg;
    logic        s6_era5_reg;
    assign s6_prod     = s5_n_reg * RECIP_365;
    assign s6_yoe_next = s6_prod[35:27];

    // stage 7: days in whole years, century count
    logic [18:0] s7_prod100;
    logic [17:0] s7_y365_reg, s7_y365_next;
    logic [1:0]  s7_q100_reg, s7_q100_next;
    logic [8:0]  s7_yoe_reg;
    tod_t        s7_tod_reg;
    logic [17:0] s7_doe_reg;
    logic        s7_era5_reg;
    assign s7_prod100   = s6_yoe_reg * RECIP_100;
    assign s7_q100_next = s7_prod100[17:16];
    assign s7_y365_next = s6_yoe_reg * 9'd365;

    // stage 8: day of march-based year
    logic [17:0] s8_ydays;
    logic [17:0] s8_diff;
    logic [8:0]  s8_doy_reg, s8_doy_next;
    logic [8:0]  s8_yoe_reg;
    tod_t        s8_tod_reg;
    logic        s8_era5_reg;
    assign s8_ydays    = s7_y365_reg + {11'd0, s7_yoe_reg[8:2]} - {16'd0, s7_q100_reg};
    assign s8_diff     = s7_doe_reg - s8_ydays;
    assign s8_doy_next = s8_diff[8:0];

    // stage 9: march-based month index
    logic [10:0] s9_v;
    logic [22:0] s9_prod;
    logic [3:0]  s9_mp_reg, s9_mp_next;
    logic [8:0]  s9_doy_reg;
    logic [8:0]  s9_yoe_reg;
    tod_t        s9_tod_reg;
    logic        s9_era5_reg;
    assign s9_v       = {s8_doy_reg, 2'b00} + {2'b00, s8_doy_reg} + 11'd2;
    assign s9_prod    = s9_v * RECIP_153;
    assign s9_mp_next = s9_prod[22:19];

    // stage 10: civil date out
    logic [8:0]  s10_dday;
    logic [11:0] s10_base;
    logic        s10_jan_feb;
    logic [11:0] year_next;
    logic [3:0]  month_next;
    logic [4:0]  day_next;
    tod_t        out_tod_reg;
    assign s10_dday    = s9_doy_reg - month_start(s9_mp_reg) + 9'd1;
    assign s10_base    = s9_era5_reg ? ERA5_YEAR : ERA4_YEAR;
    assign s10_jan_feb = (s9_mp_reg >= 4'd10);
    assign year_next   = {3'd0, s9_yoe_reg} + s10_base + {11'd0, s10_jan_feb};
    assign month_next  = s10_jan_feb ? (s9_mp_reg - 4'd9) : (s9_mp_reg + 4'd3);
    assign day_next    = s10_dday[4:0];

    // pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        s1_t_reg     <= s1_t_next;

        s2_days_reg  <= s2_days_next;
        s2_t_reg     <= s1_t_reg;

        s3_rem_reg   <= s3_rem_next;
        s3_doe_reg   <= s3_doe_next;
        s3_era5_reg  <= s3_era5_next;

        s4_hr_reg    <= s4_hr_next;
        s4_mins_reg  <= s4_mins_next;
        s4_a_reg     <= s4_a_next;
        s4_b_reg     <= s4_b_next;
        s4_c_reg     <= s4_c_next;
        s4_rem_reg   <= s3_rem_reg;
        s4_doe_reg   <= s3_doe_reg;
        s4_era5_reg  <= s3_era5_reg;

        s5_tod_reg   <= s5_tod_next;
        s5_n_reg     <= s5_n_next;
        s5_doe_reg   <= s4_doe_reg;
        s5_era5_reg  <= s4_era5_reg;

        s6_yoe_reg   <= s6_yoe_next;
        s6_tod_reg   <= s5_tod_reg;
        s6_doe_reg   <= s5_doe_reg;
        s6_era5_reg  <= s5_era5_reg;

        s7_y365_reg  <= s7_y365_next;
        s7_q100_reg  <= s7_q100_next;
        s7_yoe_reg   <= s6_yoe_reg;
        s7_tod_reg   <= s6_tod_reg;
        s7_doe_reg   <= s6_doe_reg;
        s7_era5_reg  <= s6_era5_reg;

        s8_doy_reg   <= s8_doy_next;
        s8_yoe_reg   <= s7_yoe_reg;
        s8_tod_reg   <= s7_tod_reg;
        s8_era5_reg  <= s7_era5_reg;

        s9_mp_reg    <= s9_mp_next;
        s9_doy_reg   <= s8_doy_reg;
        s9_yoe_reg   <= s8_yoe_reg;
        s9_tod_reg   <= s8_tod_reg;
        s9_era5_reg  <= s8_era5_reg;

        year         <= year_next;
        month        <= month_next;
        day_of_month <= day_next;
        out_tod_reg  <= s9_tod_reg;
    end

    assign hour   = out_tod_reg.hr;
    assign minute = out_tod_reg.mn;
    assign second = out_tod_reg.sc;

endmodule

`default_nettype wire

// File: sv/usc_checker.sv
`default_nettype none

module usc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [11:0]                year,
    input logic [3:0]                 month,
    input logic [4:0]                 day_of_month,
    input logic [4:0]                 hour,
    input logic [5:0]                 minute,
    input logic [5:0]                 second
);
    import usc_pkg::*;

    // every accepted beat gives a done beat after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("done missing after accepted start");

    // no done beat without an accepted start the same latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("done without matching start");

    // date fields stay within the calendar
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
                  && year >= 12'd1970 && year <= 12'd2106))
        else $error("date field out of range");

    // time of day fields stay within the clock
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("time field out of range");

endmodule

bind unix_seconds_to_calendar usc_checker u_usc_checker (.*);

`default_nettype wire
